// ===== rtl/scp_pkg.sv =====
// Shared types, codes and reply string tables for the serial-line CAN command parser.
`timescale 1ns / 1ps
`default_nettype none
package scp_pkg;

  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_BEL = 8'd7;

  localparam int unsigned KIND_W = 3;
  localparam int unsigned IDX_W  = 3;

  // reply kinds
  localparam logic [KIND_W-1:0] KIND_ACK    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NACK   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_VER    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_VER_SW = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SERIAL = 3'd4;
  localparam logic [KIND_W-1:0] KIND_FLAGS  = 3'd5;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              frame_valid;
    logic [28:0]       frame_id;
    logic              frame_extended;
    logic              frame_remote;
    logic [3:0]        frame_length;
    logic [63:0]       frame_data;
    logic              timestamp_on;
    logic              bus_open;
  } reply_req_t;

  function automatic logic [IDX_W-1:0] reply_last_idx(input logic [KIND_W-1:0] kind);
    logic [IDX_W-1:0] r;
    case (kind)
      KIND_VER, KIND_VER_SW, KIND_SERIAL: r = 3'd5;
      KIND_FLAGS:                         r = 3'd3;
      default:                            r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] reply_byte(input logic [KIND_W-1:0] kind,
                                            input logic [IDX_W-1:0]  idx);
    logic [7:0] b;
    b = CH_CR;
    case (kind)
      KIND_NACK: b = CH_BEL;
      KIND_VER: begin
        case (idx)
          3'd0:    b = "V";
          3'd1:    b = "1";
          3'd2:    b = "0";
          3'd3:    b = "1";
          3'd4:    b = "3";
          default: b = CH_CR;
        endcase
      end
      KIND_VER_SW: begin
        case (idx)
          3'd0:    b = "v";
          3'd1:    b = "1";
          3'd2:    b = "0";
          3'd3:    b = "1";
          3'd4:    b = "4";
          default: b = CH_CR;
        endcase
      end
      KIND_SERIAL: begin
        case (idx)
          3'd0:    b = "N";
          3'd1:    b = "4";
          3'd2:    b = "2";
          3'd3:    b = "4";
          3'd4:    b = "2";
          default: b = CH_CR;
        endcase
      end
      KIND_FLAGS: begin
        case (idx)
          3'd0:    b = "F";
          3'd1:    b = "0";
          3'd2:    b = "0";
          default: b = CH_CR;
        endcase
      end
      default: b = CH_CR;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/slcan_command_parser_unit.sv =====
// Top level of the serial-line CAN ASCII command parser.
// Takes one received character per cycle and parses CR-terminated command lines.
// A character that does not end a line produces nothing. The CR of a started
// line loads that line's reply (1 to 6 bytes) into the reply register, which sends
// one byte per cycle while out_ready_i is high; input stalls while a reply is
// pending and opens again in the cycle its final byte is taken. A t, T, r or R
// frame travels with its single acknowledge byte; timestamp_on_o and bus_open_o
// give the flags as left by the line being answered.
`timescale 1ns / 1ps
`default_nettype none
module slcan_command_parser_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_char_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       reply_char_o,
  output logic             last_o,
  output logic             frame_valid_o,
  output logic [28:0]      frame_id_o,
  output logic             frame_extended_o,
  output logic             frame_remote_o,
  output logic [3:0]       frame_length_o,
  output logic [63:0]      frame_data_o,
  output logic             timestamp_on_o,
  output logic             bus_open_o
);
  import scp_pkg::*;

  logic       accept;
  logic       req_valid;
  logic       can_load;
  reply_req_t req;
  reply_req_t cur;

  assign in_ready_o = can_load;
  assign accept     = in_valid_i && can_load;

  scp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_char_i   (rx_char_i),
    .req_valid_o (req_valid),
    .req_o       (req)
  );

  scp_reply u_reply (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (req_valid),
    .req_i        (req),
    .can_load_o   (can_load),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .reply_char_o (reply_char_o),
    .last_o       (last_o),
    .cur_o        (cur)
  );

  assign frame_valid_o    = cur.frame_valid;
  assign frame_id_o       = cur.frame_id;
  assign frame_extended_o = cur.frame_extended;
  assign frame_remote_o   = cur.frame_remote;
  assign frame_length_o   = cur.frame_length;
  assign frame_data_o     = cur.frame_data;
  assign timestamp_on_o   = cur.timestamp_on;
  assign bus_open_o       = cur.bus_open;

  // a frame always rides on a lone acknowledge
  a_frame_on_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_valid_o) |-> (reply_char_o == CH_CR && last_o))
    else $error("frame without single ack byte");

  a_frame_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_valid_o) |-> (frame_length_o <= 4'd8))
    else $error("frame length above 8");

  // input only stalls behind a pending reply
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no reply pending");

  // a multi-byte reply continues after a non-final byte is taken
  a_reply_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_o) |=> out_valid_o)
    else $error("reply cut short");

endmodule
`default_nettype wire

// ===== rtl/scp_parser.sv =====
// Line parser: command letter, position and hex field accumulators, reply decode on CR.
`timescale 1ns / 1ps
`default_nettype none
module scp_parser (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [7:0]        rx_char_i,
  output logic                   req_valid_o,
  output scp_pkg::reply_req_t    req_o
);
  import scp_pkg::*;

  logic [7:0]  cmd_q, cmd_d;
  logic [4:0]  pos_q, pos_d;
  logic [31:0] id_q, id_d;
  logic [3:0]  len_q, len_d;
  logic        len_ok_q, len_ok_d;
  logic [63:0] data_q, data_d;
  logic        sec_q, sec_d;
  logic        ts_q, ts_d;
  logic        open_q, open_d;

  logic        is_cr, cmd_zero, is_std, is_ext, is_data_cmd;
  logic [4:0]  id_len;
  logic        hex_ok;
  logic [3:0]  hex_nib;
  logic [4:0]  data_off;
  logic [3:0]  byte_k;
  logic [7:0]  old_byte;
  logic        sec_eff;
  logic        ts_new, open_new;
  reply_req_t  req;

  always_comb begin
    hex_ok  = 1'b1;
    hex_nib = 4'd0;
    if (rx_char_i >= "0" && rx_char_i <= "9") begin
      hex_nib = 4'(rx_char_i - "0");
    end else if (rx_char_i >= "A" && rx_char_i <= "F") begin
      hex_nib = 4'(rx_char_i - "A" + 8'd10);
    end else if (rx_char_i >= "a" && rx_char_i <= "f") begin
      hex_nib = 4'(rx_char_i - "a" + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign is_cr       = (rx_char_i == CH_CR);
  assign cmd_zero    = (cmd_q == 8'd0);
  assign is_std      = (cmd_q == "t") || (cmd_q == "r");
  assign is_ext      = (cmd_q == "T") || (cmd_q == "R");
  assign is_data_cmd = (cmd_q == "t") || (cmd_q == "T");
  assign id_len      = is_ext ? 5'd8 : 5'd3;
  assign data_off    = pos_q - id_len - 5'd2;
  assign byte_k      = data_off[4:1];
  assign old_byte    = data_q[{byte_k[2:0], 3'b000} +: 8];
  assign sec_eff     = (pos_q == 5'd1) ? 1'b1 : sec_q;

  // reply decode for a CR that closes a started line
  always_comb begin
    req          = '0;
    req.kind     = KIND_NACK;
    ts_new       = ts_q;
    open_new     = open_q;
    case (cmd_q)
      "m", "M", "S", "U", "s": req.kind = KIND_ACK;
      "Z": begin
        ts_new   = sec_eff;
        req.kind = KIND_ACK;
      end
      "O": begin
        open_new = 1'b1;
        req.kind = KIND_ACK;
      end
      "C": begin
        open_new = 1'b0;
        req.kind = KIND_ACK;
      end
      "X": req.kind = sec_eff ? KIND_ACK : KIND_NACK;
      "V": req.kind = KIND_VER;
      "v": req.kind = KIND_VER_SW;
      "N": req.kind = KIND_SERIAL;
      "F": req.kind = KIND_FLAGS;
      "t", "T", "r", "R": begin
        if (len_ok_q) begin
          req.kind           = KIND_ACK;
          req.frame_valid    = 1'b1;
          req.frame_extended = is_ext;
          req.frame_remote   = (cmd_q == "r") || (cmd_q == "R");
          req.frame_id       = is_ext ? id_q[28:0] : {18'd0, id_q[10:0]};
          req.frame_length   = len_q;
          req.frame_data     = req.frame_remote ? 64'd0 : data_q;
        end
      end
      default: req.kind = KIND_NACK;
    endcase
    req.timestamp_on = ts_new;
    req.bus_open     = open_new;
  end

  assign req_valid_o = accept_i && is_cr && !cmd_zero;
  assign req_o       = req;

  always_comb begin
    cmd_d    = cmd_q;
    pos_d    = pos_q;
    id_d     = id_q;
    len_d    = len_q;
    len_ok_d = len_ok_q;
    data_d   = data_q;
    sec_d    = sec_q;
    ts_d     = ts_q;
    open_d   = open_q;
    if (accept_i) begin
      if (!is_cr) begin
        if (cmd_zero) begin
          // a zero byte starts no line
          if (rx_char_i != 8'd0) begin
            cmd_d    = rx_char_i;
            pos_d    = 5'd1;
            id_d     = '0;
            len_d    = '0;
            len_ok_d = 1'b0;
            data_d   = '0;
            sec_d    = 1'b0;
          end
        end else begin
          if (cmd_q == "Z" || cmd_q == "X") begin
            if (pos_q == 5'd1) sec_d = rx_char_i[0];
          end else if (is_std || is_ext) begin
            if (pos_q >= 5'd1 && pos_q <= id_len) begin
              if (hex_ok) id_d = {id_q[27:0], hex_nib};
            end else if (pos_q == id_len + 5'd1) begin
              len_ok_d = (rx_char_i >= "0") && (rx_char_i <= "8");
              len_d    = len_ok_d ? 4'(rx_char_i - "0") : 4'd0;
            end else if (pos_q > id_len + 5'd1 && len_ok_q && is_data_cmd) begin
              // shift the nibble into data byte k
              if (byte_k < len_q && hex_ok) begin
                data_d[{byte_k[2:0], 3'b000} +: 8] = {old_byte[3:0], hex_nib};
              end
            end
          end
          if (pos_q != 5'd31) pos_d = pos_q + 5'd1;
        end
      end else if (!cmd_zero) begin
        cmd_d    = '0;
        pos_d    = '0;
        id_d     = '0;
        len_d    = '0;
        len_ok_d = 1'b0;
        data_d   = '0;
        sec_d    = 1'b0;
        ts_d     = ts_new;
        open_d   = open_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q    <= '0;
      pos_q    <= '0;
      id_q     <= '0;
      len_q    <= '0;
      len_ok_q <= 1'b0;
      data_q   <= '0;
      sec_q    <= 1'b0;
      ts_q     <= 1'b0;
      open_q   <= 1'b0;
    end else begin
      cmd_q    <= cmd_d;
      pos_q    <= pos_d;
      id_q     <= id_d;
      len_q    <= len_d;
      len_ok_q <= len_ok_d;
      data_q   <= data_d;
      sec_q    <= sec_d;
      ts_q     <= ts_d;
      open_q   <= open_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/scp_reply.sv =====
// Reply register: holds one line's reply and sends its bytes one per cycle while out_ready_i is high.
`timescale 1ns / 1ps
`default_nettype none
module scp_reply (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire scp_pkg::reply_req_t req_i,
  output logic                   can_load_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [7:0]             reply_char_o,
  output logic                   last_o,
  output scp_pkg::reply_req_t    cur_o
);
  import scp_pkg::*;

  logic             busy_q, busy_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  reply_req_t       req_q, req_d;
  logic             is_last, take;

  assign is_last      = (idx_q == reply_last_idx(req_q.kind));
  assign take         = busy_q && out_ready_i;
  assign can_load_o   = !busy_q || (out_ready_i && is_last);
  assign out_valid_o  = busy_q;
  assign reply_char_o = reply_byte(req_q.kind, idx_q);
  assign last_o       = is_last;
  assign cur_o        = req_q;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    req_d  = req_q;
    if (load_i) begin
      busy_d = 1'b1;
      idx_d  = '0;
      req_d  = req_i;
    end else if (take) begin
      if (is_last) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
  end

endmodule
`default_nettype wire

// ===== tb/slcan_command_parser_unit_test.sv =====
// Self-checking testbench for the serial-line CAN command parser, with a scoreboard and random stalls.
`timescale 1ns / 1ps
module slcan_command_parser_unit_test;
  import scp_pkg::CH_CR;
  import scp_pkg::CH_BEL;

  localparam logic [7:0] CMD_STD_DATA   = "t";
  localparam logic [7:0] CMD_EXT_DATA   = "T";
  localparam logic [7:0] CMD_STD_RTR    = "r";
  localparam logic [7:0] CMD_EXT_RTR    = "R";
  localparam logic [7:0] CMD_TIMESTAMP  = "Z";
  localparam logic [7:0] CMD_OPEN       = "O";
  localparam logic [7:0] CMD_CLOSE      = "C";
  localparam logic [7:0] CMD_AUTO_POLL  = "X";
  localparam logic [7:0] CMD_VERSION    = "V";
  localparam logic [7:0] CMD_SW_VERSION = "v";
  localparam logic [7:0] CMD_SERIAL     = "N";
  localparam logic [7:0] CMD_FLAGS      = "F";
  localparam logic [7:0] CMD_ACC_CODE   = "M";
  localparam logic [7:0] CMD_ACC_MASK   = "m";
  localparam logic [7:0] CMD_BITRATE    = "S";
  localparam logic [7:0] CMD_BTR        = "s";
  localparam logic [7:0] CMD_UART       = "U";
  localparam logic [7:0] CMD_POLL       = "P";
  localparam logic [7:0] CMD_POLL_ALL   = "A";

  localparam logic [3:0][7:0] FRAME_LETTERS = {CMD_STD_DATA, CMD_EXT_DATA,
                                               CMD_STD_RTR, CMD_EXT_RTR};
  localparam int unsigned N_SIMPLE = 15;
  localparam logic [N_SIMPLE-1:0][7:0] SIMPLE_LETTERS = {
    CMD_TIMESTAMP, CMD_OPEN, CMD_CLOSE, CMD_AUTO_POLL, CMD_VERSION,
    CMD_SW_VERSION, CMD_SERIAL, CMD_FLAGS, CMD_ACC_CODE, CMD_ACC_MASK,
    CMD_BITRATE, CMD_BTR, CMD_UART, CMD_POLL, CMD_POLL_ALL};

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned RANDOM_CHARS = 190;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0]  ch;
    logic        last;
    logic        fvalid;
    logic [28:0] id;
    logic        ext;
    logic        rem;
    logic [3:0]  len;
    logic [63:0] data;
    logic        ts;
    logic        open;
  } reply_t;

  class reply_scoreboard;
    logic [7:0]  cmd_letter;
    logic [4:0]  line_pos;
    logic [31:0] id_acc;
    logic [3:0]  len_code;
    logic        len_ok;
    logic [63:0] data_acc;
    logic        second_bit;
    logic        ts_flag;
    logic        open_flag;
    reply_t      replies_due[$];
    int unsigned errors;

    function new();
      clear_line();
      ts_flag   = 1'b0;
      open_flag = 1'b0;
      errors    = 0;
    endfunction

    function void clear_line();
      cmd_letter = 8'd0;
      line_pos   = 5'd0;
      id_acc     = 32'd0;
      len_code   = 4'd0;
      len_ok     = 1'b0;
      data_acc   = 64'd0;
      second_bit = 1'b0;
    endfunction

    function reply_t plain_reply(logic [7:0] ch, logic last);
      reply_t r;
      r      = '0;
      r.ch   = ch;
      r.last = last;
      r.ts   = ts_flag;
      r.open = open_flag;
      return r;
    endfunction

    function void push_text(string s);
      for (int i = 0; i < s.len(); i++) replies_due.push_back(plain_reply(s[i], 1'b0));
      replies_due.push_back(plain_reply(CH_CR, 1'b1));
    endfunction

    // Advance the parser by one received character and queue the replies it causes.
    function void parse_char(logic [7:0] c);
      logic [4:0] nib;
      int         idlen;
      int         k;
      logic       ack;
      logic       emitted;
      logic       ext;
      logic       rem;
      reply_t     r;
      if (c >= "0" && c <= "9") nib = 5'(c - "0");
      else if (c >= "A" && c <= "F") nib = 5'(c - "A" + 10);
      else if (c >= "a" && c <= "f") nib = 5'(c - "a" + 10);
      else nib = 5'd16;
      if (c != CH_CR) begin
        if (cmd_letter == 8'd0) begin
          // a zero byte never starts a line
          if (c != 8'd0) begin
            cmd_letter = c;
            line_pos   = 5'd1;
          end
        end else begin
          if (cmd_letter == CMD_TIMESTAMP || cmd_letter == CMD_AUTO_POLL) begin
            if (line_pos == 5'd1) second_bit = c[0];
          end else if (cmd_letter == CMD_STD_DATA || cmd_letter == CMD_STD_RTR ||
                       cmd_letter == CMD_EXT_DATA || cmd_letter == CMD_EXT_RTR) begin
            idlen = (cmd_letter == CMD_STD_DATA || cmd_letter == CMD_STD_RTR) ? 3 : 8;
            if (int'(line_pos) <= idlen) begin
              if (nib < 5'd16) id_acc = {id_acc[27:0], nib[3:0]};
            end else if (int'(line_pos) == idlen + 1) begin
              len_ok   = (c >= "0" && c <= "8");
              len_code = len_ok ? 4'(c - "0") : 4'd0;
            end else if (len_ok && (cmd_letter == CMD_STD_DATA ||
                                    cmd_letter == CMD_EXT_DATA)) begin
              k = (int'(line_pos) - idlen - 2) / 2;
              if (k < int'(len_code) && nib < 5'd16)
                data_acc[8*k +: 8] = {data_acc[8*k +: 4], nib[3:0]};
            end
          end
          if (line_pos < 5'd31) line_pos++;
        end
      end else if (cmd_letter != 8'd0) begin
        // a CR right after the letter stands in as the second character
        if (line_pos == 5'd1) second_bit = 1'b1;
        ack     = 1'b0;
        emitted = 1'b0;
        case (cmd_letter)
          CMD_ACC_MASK, CMD_ACC_CODE, CMD_BITRATE, CMD_UART, CMD_BTR: ack = 1'b1;
          CMD_TIMESTAMP: begin
            ts_flag = second_bit;
            ack     = 1'b1;
          end
          CMD_OPEN: begin
            open_flag = 1'b1;
            ack       = 1'b1;
          end
          CMD_CLOSE: begin
            open_flag = 1'b0;
            ack       = 1'b1;
          end
          CMD_AUTO_POLL: ack = second_bit;
          CMD_VERSION: begin
            push_text("V1013");
            emitted = 1'b1;
          end
          CMD_SW_VERSION: begin
            push_text("v1014");
            emitted = 1'b1;
          end
          CMD_SERIAL: begin
            push_text("N4242");
            emitted = 1'b1;
          end
          CMD_FLAGS: begin
            push_text("F00");
            emitted = 1'b1;
          end
          CMD_STD_DATA, CMD_EXT_DATA, CMD_STD_RTR, CMD_EXT_RTR: begin
            if (len_ok) begin
              ext      = (cmd_letter == CMD_EXT_DATA || cmd_letter == CMD_EXT_RTR);
              rem      = (cmd_letter == CMD_STD_RTR || cmd_letter == CMD_EXT_RTR);
              r        = plain_reply(CH_CR, 1'b1);
              r.fvalid = 1'b1;
              r.id     = ext ? id_acc[28:0] : {18'd0, id_acc[10:0]};
              r.ext    = ext;
              r.rem    = rem;
              r.len    = len_code;
              r.data   = rem ? 64'd0 : data_acc;
              replies_due.push_back(r);
              emitted  = 1'b1;
            end
          end
          default: ack = 1'b0;
        endcase
        if (!emitted) replies_due.push_back(plain_reply(ack ? CH_CR : CH_BEL, 1'b1));
        clear_line();
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task cmp(string name, logic [63:0] got_v, logic [63:0] want_v);
      if (got_v !== want_v) report($sformatf("%s got %0h want %0h", name, got_v, want_v));
    endtask

    task check_reply(reply_t got);
      reply_t want;
      if (replies_due.size() == 0) begin
        report($sformatf("reply %0h with no request pending", got.ch));
        return;
      end
      want = replies_due.pop_front();
      cmp("reply_char", got.ch, want.ch);
      cmp("last", got.last, want.last);
      cmp("frame_valid", got.fvalid, want.fvalid);
      cmp("frame_id", got.id, want.id);
      cmp("frame_extended", got.ext, want.ext);
      cmp("frame_remote", got.rem, want.rem);
      cmp("frame_length", got.len, want.len);
      cmp("frame_data", got.data, want.data);
      cmp("timestamp_on", got.ts, want.ts);
      cmp("bus_open", got.open, want.open);
    endtask
  endclass

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic [7:0]  rx_char   = 8'd0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [7:0]  reply_char;
  logic        last;
  logic        frame_valid;
  logic [28:0] frame_id;
  logic        frame_extended;
  logic        frame_remote;
  logic [3:0]  frame_length;
  logic [63:0] frame_data;
  logic        timestamp_on;
  logic        bus_open;

  bit          calm         = 1'b0;
  bit          hold_out     = 1'b0;
  int unsigned chars_sent   = 0;
  int unsigned quiet_cycles = 0;

  reply_scoreboard sb = new();

  slcan_command_parser_unit i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .rx_char_i        (rx_char),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .reply_char_o     (reply_char),
    .last_o           (last),
    .frame_valid_o    (frame_valid),
    .frame_id_o       (frame_id),
    .frame_extended_o (frame_extended),
    .frame_remote_o   (frame_remote),
    .frame_length_o   (frame_length),
    .frame_data_o     (frame_data),
    .timestamp_on_o   (timestamp_on),
    .bus_open_o       (bus_open)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin : monitor
    reply_t got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.ch     = reply_char;
        got.last   = last;
        got.fvalid = frame_valid;
        got.id     = frame_id;
        got.ext    = frame_extended;
        got.rem    = frame_remote;
        got.len    = frame_length;
        got.data   = frame_data;
        got.ts     = timestamp_on;
        got.open   = bus_open;
        sb.check_reply(got);
      end
      if (in_valid && in_ready) sb.parse_char(rx_char);
      if ((out_valid && out_ready) || (in_valid && in_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Reply side: random backpressure, plus one long hold when requested.
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_out) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_out = 1'b0;
      end
      out_ready = calm || ($urandom_range(0, 99) >= 18);
    end
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'("0" + n);
    return 8'(($urandom_range(0, 1) ? "A" : "a") + n - 10);
  endfunction

  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_CR);
    return c;
  endfunction

  // Entered and left just after a falling edge.
  task automatic send_char(input logic [7:0] c);
    while (!calm && $urandom_range(0, 99) < 18) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    rx_char  = c;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    send_char(CH_CR);
  endtask

  task automatic send_random_line();
    logic [7:0] q[$];
    logic [7:0] letter;
    int         idlen;
    int         len;
    int         pick;
    int         id_sel;
    int         data_sel;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      letter   = FRAME_LETTERS[$urandom_range(0, 3)];
      idlen    = (letter == CMD_STD_DATA || letter == CMD_STD_RTR) ? 3 : 8;
      id_sel   = $urandom_range(0, 9);
      data_sel = $urandom_range(0, 9);
      q.push_back(letter);
      for (int i = 0; i < idlen; i++) begin
        if ($urandom_range(0, 11) == 0) q.push_back(noise_char());
        q.push_back(hex_char(id_sel == 0 ? 4'h0 : id_sel == 1 ? 4'hF :
                             4'($urandom_range(0, 15))));
      end
      len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 8) : -1;
      q.push_back(len >= 0 ? 8'("0" + len) : noise_char());
      for (int i = 0; i < 2 * len; i++) begin
        if ($urandom_range(0, 15) == 0) q.push_back(noise_char());
        q.push_back(hex_char(data_sel == 0 ? 4'h0 : data_sel == 1 ? 4'hF :
                             4'($urandom_range(0, 15))));
      end
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 6)) q.push_back(noise_char());
      // cut the line short now and then, always keeping the letter
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(0, q.size() - 1)) void'(q.pop_back());
    end else if (pick < 82) begin
      letter = ($urandom_range(0, 7) == 0) ? noise_char()
                                           : SIMPLE_LETTERS[$urandom_range(0, N_SIMPLE - 1)];
      q.push_back(letter);
      if ((letter == CMD_TIMESTAMP || letter == CMD_AUTO_POLL) && $urandom_range(0, 3) != 0)
        q.push_back($urandom_range(0, 2) == 0 ? noise_char() :
                    ($urandom_range(0, 1) ? 8'("1") : 8'("0")));
      repeat ($urandom_range(0, 2)) q.push_back(noise_char());
    end else if (pick < 94) begin
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(20, 40) : $urandom_range(1, 8))
        q.push_back(noise_char());
    end else if ($urandom_range(0, 1) == 0) begin
      q.push_back(8'd0);
    end
    q.push_back(CH_CR);
    foreach (q[i]) send_char(q[i]);
  endtask

  initial begin : stimulus
    int unsigned lines;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    // empty line, ignored zero byte, flags with the second character missing,
    // status flags string, widest remote frame, out-of-range length
    send_char(CH_CR);
    send_char(8'd0);
    send_text("Z");
    send_text("X");
    send_text("X0");
    send_text("F");
    send_text("r7FF8");
    send_text("t0009");
    chars_sent = 0;
    lines      = 0;
    while (chars_sent < RANDOM_CHARS) begin
      if (lines == 4) hold_out = 1'b1;
      if (lines == 9) begin
        while (sb.replies_due.size() != 0) begin
          in_valid = 1'b0;
          @(negedge clk);
        end
      end
      calm = (lines >= 10 && lines < 16);
      send_random_line();
      lines++;
    end
    in_valid = 1'b0;
    calm     = 1'b0;
    while (sb.replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.replies_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
